FILE: rtl/vcrd_pkg.sv
// ============================================================================
// vcrd_pkg
// shared types and constants for the voxel column run decoder
// ============================================================================
`default_nettype none

package vcrd_pkg;

    localparam logic [7:0] DATA_MASK = 8'h7F;
    localparam logic [7:0] CONT_FLAG = 8'h80;

    localparam logic [1:0] REG_DEPTH_Z      = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_ID_WIDTH     = 2'd2;

    localparam logic [2:0] PH_DELTA = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_RUN   = 3'd3;
    localparam logic [2:0] PH_IDHI  = 3'd4;
    localparam logic [2:0] PH_IDLO  = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // work item passed from the byte parser to the divider back end
    typedef struct packed {
        logic        is_end;
        logic [31:0] column_index;
        logic [16:0] y_start;
        logic [16:0] run_length;
        logic [15:0] local_id;
    } job_t;

    // result record leaving the back end
    typedef struct packed {
        logic        record_kind;
        logic [15:0] grid_x;
        logic [15:0] grid_z;
        logic [15:0] y_start;
        logic [16:0] run_length;
        logic [15:0] local_id;
    } rec_t;

endpackage

`default_nettype wire

FILE: rtl/vcrd_parser.sv
// ============================================================================
// vcrd_parser
// byte front end: varint collection, field sequencing, job generation
// ============================================================================
`default_nettype none

module vcrd_parser #(
    parameter int COORD_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    byte_data,
    input  wire logic [31:0]   column_count,
    input  wire logic [1:0]    id_width,
    input  wire logic          space2,
    output logic               byte_ready,
    output logic [1:0]         job_count,
    output vcrd_pkg::job_t     job0,
    output vcrd_pkg::job_t     job1
);
    import vcrd_pkg::*;

    localparam logic [16:0] LIMIT = 17'(1 << COORD_BITS);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] segs_reg, segs_next;
    logic [16:0] y_reg, y_next;
    logic [16:0] run_reg, run_next;
    logic [7:0]  idhi_reg, idhi_next;

    logic        fin;
    logic [31:0] val;
    logic [31:0] shifted;
    logic [17:0] ysum;
    logic [32:0] runp;
    logic [31:0] done_inc;
    logic        emit;
    logic [15:0] id_val;
    job_t        end_job;

    // worst case a byte creates two jobs
    assign byte_ready = space2;

    always_comb
    begin
        shifted = 32'({1'b0, byte_data[6:0]}) << shift_reg;
        val     = acc_reg | (shift_reg < 6'd32 ? shifted : 32'd0);
        fin     = (byte_data & CONT_FLAG) == 8'd0;
    end

    always_comb
    begin
        end_job = '0;
        end_job.is_end = 1'b1;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        col_next   = col_reg;
        done_next  = done_reg;
        segs_next  = segs_reg;
        y_next     = y_reg;
        run_next   = run_reg;
        idhi_next  = idhi_reg;
        job_count  = 2'd0;
        job0       = end_job;
        job1       = end_job;
        emit       = 1'b0;
        id_val     = {8'd0, byte_data};
        done_inc   = done_reg + 32'd1;
        ysum       = 18'(y_reg) + 18'(run_reg);
        runp       = 33'(val) + 33'd1;

        if (byte_valid && byte_ready)
        begin
            if (phase_reg != PH_DONE && phase_reg != PH_IDHI && phase_reg != PH_IDLO &&
                !(phase_reg == PH_DELTA && done_reg >= column_count))
            begin
                if (shift_reg < 6'd32)
                    shift_next = shift_reg + 6'd7;
                acc_next = val;
                if (fin)
                begin
                    acc_next   = '0;
                    shift_next = '0;
                end
            end
            unique case (phase_reg)
                PH_DELTA:
                begin
                    if (done_reg >= column_count)
                    begin
                        phase_next = PH_DONE;
                        job_count  = 2'd1;
                    end
                    else if (fin)
                    begin
                        col_next   = col_reg + val;
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (fin)
                    begin
                        y_next    = '0;
                        segs_next = val;
                        if (val == 32'd0)
                        begin
                            done_next  = done_inc;
                            phase_next = PH_DELTA;
                            if (done_inc >= column_count)
                            begin
                                phase_next = PH_DONE;
                                job_count  = 2'd1;
                            end
                        end
                        else
                            phase_next = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    if (fin)
                    begin
                        if (val >= 32'(LIMIT) || (33'(y_reg) + 33'(val)) > 33'(LIMIT))
                            y_next = LIMIT;
                        else
                            y_next = 17'(y_reg + val[16:0]);
                        phase_next = PH_RUN;
                    end
                end
                PH_RUN:
                begin
                    if (fin)
                    begin
                        run_next   = runp > 33'(LIMIT) ? LIMIT : runp[16:0];
                        phase_next = PH_IDHI;
                    end
                end
                PH_IDHI:
                begin
                    if (id_width == 2'd2)
                    begin
                        idhi_next  = byte_data;
                        phase_next = PH_IDLO;
                    end
                    else
                        emit = 1'b1;
                end
                PH_IDLO:
                begin
                    id_val = {idhi_reg, byte_data};
                    emit   = 1'b1;
                end
                default:
                    phase_next = PH_DONE;
            endcase

            if (emit)
            begin
                job0.is_end       = 1'b0;
                job0.column_index = col_reg;
                job0.y_start      = y_reg;
                job0.run_length   = run_reg;
                job0.local_id     = id_val;
                job_count         = 2'd1;
                y_next    = ysum > 18'(LIMIT) ? LIMIT : ysum[16:0];
                segs_next = segs_reg - 32'd1;
                phase_next = PH_GAP;
                if (segs_reg == 32'd1)
                begin
                    done_next  = done_inc;
                    phase_next = PH_DELTA;
                    if (done_inc >= column_count)
                    begin
                        phase_next = PH_DONE;
                        job_count  = 2'd2;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            acc_reg   <= '0;
            shift_reg <= '0;
            col_reg   <= '0;
            done_reg  <= '0;
            segs_reg  <= '0;
            y_reg     <= '0;
            run_reg   <= '0;
            idhi_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
            segs_reg  <= segs_next;
            y_reg     <= y_next;
            run_reg   <= run_next;
            idhi_reg  <= idhi_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vcrd_job_fifo.sv
// ============================================================================
// vcrd_job_fifo
// small job queue between parser and divider, up to two pushes per cycle
// ============================================================================
`default_nettype none

module vcrd_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    push_count,
    input  vcrd_pkg::job_t     push0,
    input  vcrd_pkg::job_t     push1,
    output logic               space2,
    output logic               not_empty,
    output vcrd_pkg::job_t     head,
    input  wire logic          pop_head
);
    import vcrd_pkg::*;

    localparam int DEPTH = 4;

    job_t       slot_reg [DEPTH];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;

    assign space2    = cnt_reg <= 3'(DEPTH - 2);
    assign not_empty = cnt_reg != 3'd0;
    assign head      = slot_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg + 2'(pop_head);
        wr_next  = wr_reg + push_count;
        cnt_next = cnt_reg + 3'(push_count) - 3'(pop_head);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            slot_reg[wr_reg] <= push0;
        if (push_count == 2'd2)
            slot_reg[wr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vcrd_divider.sv
// ============================================================================
// vcrd_divider
// back end: restoring divide of column index by depth, one bit per cycle
// ============================================================================
`default_nettype none

module vcrd_divider #(
    parameter int COORD_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  vcrd_pkg::job_t     job,
    output logic               job_take,
    input  wire logic [15:0]   depth_z,
    output logic               rec_valid,
    output vcrd_pkg::rec_t     rec,
    input  wire logic          rec_take
);
    import vcrd_pkg::*;

    localparam logic [31:0] CMAX = 32'((1 << COORD_BITS) - 1);

    logic        busy_reg, busy_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    job_t        job_reg, job_next;
    logic        out_valid_reg, out_valid_next;
    rec_t        out_reg, out_next;
    logic [16:0] trial;
    logic [16:0] rem_sh;

    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;
    assign job_take  = !busy_reg && job_valid;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !rec_take;
        out_next       = out_reg;
        rem_sh         = {rem_reg[15:0], quo_reg[31]};
        trial          = rem_sh - 17'(div_reg);

        if (job_take)
        begin
            busy_next = 1'b1;
            step_next = '0;
            job_next  = job;
            quo_next  = job.column_index;
            rem_next  = '0;
            div_next  = depth_z == 16'd0 ? 16'd1 : depth_z;
        end
        else if (busy_reg && step_reg != 6'd32)
        begin
            if (rem_sh >= 17'(div_reg))
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
        end
        else if (busy_reg && !out_valid_next)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_next       = '0;
            if (job_reg.is_end)
                out_next.record_kind = 1'b1;
            else
            begin
                out_next.grid_x     = 16'(quo_reg > CMAX ? CMAX : quo_reg);
                out_next.grid_z     = 16'(32'(rem_reg) > CMAX ? CMAX : 32'(rem_reg));
                out_next.y_start    = 16'(32'(job_reg.y_start) > CMAX ? CMAX
                                           : 32'(job_reg.y_start));
                out_next.run_length = job_reg.run_length;
                out_next.local_id   = job_reg.local_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/voxel_column_run_decoder_unit.sv
// ============================================================================
// voxel_column_run_decoder_unit
// decodes a varint run-length voxel stream into segment records
// ============================================================================
// The parser takes one stream byte per cycle while its job queue has room for
// two entries. Each segment (and the end marker) then passes a divider that
// splits the column index into x and z at one quotient bit per cycle and
// takes no new job until its record is registered; the four-entry queue lets
// byte intake run ahead until records pile up. End of stream is one record
// with record_kind set; later bytes are swallowed until reset.
`default_nettype none

module voxel_column_run_decoder_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  stream_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             record_kind,
    output logic [15:0]      grid_x,
    output logic [15:0]      grid_z,
    output logic [15:0]      y_start,
    output logic [16:0]      run_length,
    output logic [15:0]      local_id,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import vcrd_pkg::*;

    logic [15:0] depth_reg;
    logic [31:0] count_reg;
    logic [1:0]  idw_reg;
    logic        space2, ready, not_empty, take, rv;
    logic [1:0]  job_count;
    job_t        job0, job1, head;
    rec_t        rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= 16'd1;
            count_reg <= '0;
            idw_reg   <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEPTH_Z:      depth_reg <= cfg_data[15:0];
                REG_COLUMN_COUNT: count_reg <= cfg_data;
                REG_ID_WIDTH:     idw_reg   <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    vcrd_parser #(.COORD_BITS(COORD_BITS)) u_parser (
        .clk, .rst_n,
        .byte_valid(push), .byte_data(stream_byte),
        .column_count(count_reg), .id_width(idw_reg), .space2,
        .byte_ready(ready), .job_count, .job0, .job1
    );

    vcrd_job_fifo u_fifo (
        .clk, .rst_n, .push_count(job_count), .push0(job0), .push1(job1),
        .space2, .not_empty, .head, .pop_head(take)
    );

    vcrd_divider #(.COORD_BITS(COORD_BITS)) u_div (
        .clk, .rst_n, .job_valid(not_empty), .job(head), .job_take(take),
        .depth_z(depth_reg), .rec_valid(rv), .rec, .rec_take(pop)
    );

    assign full        = !ready;
    assign empty       = !rv;
    assign record_kind = rec.record_kind;
    assign grid_x      = rec.grid_x;
    assign grid_z      = rec.grid_z;
    assign y_start     = rec.y_start;
    assign run_length  = rec.run_length;
    assign local_id    = rec.local_id;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !space2 |-> job_count == 2'd0) else $error("job queue overrun");
    a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record_kind) |-> (grid_x == 16'd0 && run_length == 17'd0))
        else $error("end record carries data");
    a_seg_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !record_kind) |-> run_length != 17'd0)
        else $error("segment with zero run");

endmodule

`default_nettype wire

FILE: tb/voxel_column_run_decoder_unit_tb.sv
// ============================================================================
// voxel_column_run_decoder_unit_tb
// drives varint voxel column streams into the decoder and checks each record
// against a cycle-free model of the decoder kept in the bench
// ============================================================================
`default_nettype none

module voxel_column_run_decoder_unit_tb;
    import vcrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 300;
    localparam logic [16:0] Y_LIMIT = 17'h10000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  stream_byte = 8'h00;
    logic        pop = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_DEPTH_Z;
    logic [31:0] cfg_data = 32'h0;
    logic        full;
    logic        empty;
    logic        record_kind;
    logic [15:0] grid_x;
    logic [15:0] grid_z;
    logic [15:0] y_start;
    logic [16:0] run_length;
    logic [15:0] local_id;

    voxel_column_run_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .stream_byte (stream_byte),
        .empty       (empty),
        .pop         (pop),
        .record_kind (record_kind),
        .grid_x      (grid_x),
        .grid_z      (grid_z),
        .y_start     (y_start),
        .run_length  (run_length),
        .local_id    (local_id),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // decoder copy
    logic [15:0] depth_z_r;
    logic [31:0] col_count_r;
    logic [1:0]  id_width_r;
    logic [2:0]  dec_phase;
    logic [31:0] acc;
    logic [5:0]  acc_shift;
    logic [31:0] col_idx;
    logic [31:0] cols_done;
    logic [31:0] segs_left;
    logic [16:0] y_pos;
    logic [16:0] run_len;
    logic [7:0]  id_hi;

    rec_t expected_recs[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   pop_stall_pct = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk) begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 30)
            $display("tb: mismatch %s got %0h want %0h at cycle %0d",
                     what, got, want, cycles);
        mismatches++;
    endtask

    // record check
    always @(posedge clk) begin
        rec_t w;
        if (rst_n && pop && !empty) begin
            if (expected_recs.size() == 0) begin
                report_mismatch("unexpected record", 32'(grid_x), 32'h0);
            end
            else begin
                w = expected_recs.pop_front();
                if (record_kind !== w.record_kind)
                    report_mismatch("record_kind", 32'(record_kind), 32'(w.record_kind));
                if (grid_x !== w.grid_x)
                    report_mismatch("grid_x", 32'(grid_x), 32'(w.grid_x));
                if (grid_z !== w.grid_z)
                    report_mismatch("grid_z", 32'(grid_z), 32'(w.grid_z));
                if (y_start !== w.y_start)
                    report_mismatch("y_start", 32'(y_start), 32'(w.y_start));
                if (run_length !== w.run_length)
                    report_mismatch("run_length", 32'(run_length), 32'(w.run_length));
                if (local_id !== w.local_id)
                    report_mismatch("local_id", 32'(local_id), 32'(w.local_id));
            end
        end
    end

    task automatic push_end_record();
        rec_t r;
        r = '0;
        r.record_kind = 1'b1;
        expected_recs.push_back(r);
    endtask

    task automatic finish_column();
        cols_done++;
        dec_phase = PH_DELTA;
        if (cols_done >= col_count_r) begin
            dec_phase = PH_DONE;
            push_end_record();
        end
    endtask

    task automatic emit_segment(input logic [15:0] id);
        rec_t        r;
        logic [31:0] d;
        logic [31:0] x;
        logic [31:0] z;
        logic [33:0] t;
        d = (depth_z_r == 16'h0) ? 32'd1 : 32'(depth_z_r);
        x = col_idx / d;
        z = col_idx % d;
        r.record_kind = 1'b0;
        r.grid_x = (x > 32'hFFFF) ? 16'hFFFF : x[15:0];
        r.grid_z = (z > 32'hFFFF) ? 16'hFFFF : z[15:0];
        r.y_start = (y_pos > 17'hFFFF) ? 16'hFFFF : y_pos[15:0];
        r.run_length = run_len;
        r.local_id = id;
        expected_recs.push_back(r);
        t = 34'(y_pos) + 34'(run_len);
        y_pos = (t > 34'(Y_LIMIT)) ? Y_LIMIT : t[16:0];
        segs_left--;
        if (segs_left == 0)
            finish_column();
        else
            dec_phase = PH_GAP;
    endtask

    task automatic take_varint(input logic [7:0] b, output bit done,
                               output logic [31:0] v);
        if (acc_shift < 6'd32) begin
            acc = acc | (32'(b & DATA_MASK) << acc_shift);
            acc_shift = acc_shift + 6'd7;
        end
        done = ((b & CONT_FLAG) == 8'h00);
        v = acc;
        if (done) begin
            acc = '0;
            acc_shift = '0;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        bit          done;
        logic [31:0] v;
        logic [33:0] t;
        case (dec_phase)
            PH_DELTA: begin
                if (cols_done >= col_count_r) begin
                    dec_phase = PH_DONE;
                    push_end_record();
                end
                else begin
                    take_varint(b, done, v);
                    if (done) begin
                        col_idx = col_idx + v;
                        dec_phase = PH_COUNT;
                    end
                end
            end
            PH_COUNT: begin
                take_varint(b, done, v);
                if (done) begin
                    y_pos = '0;
                    segs_left = v;
                    if (v == 0)
                        finish_column();
                    else
                        dec_phase = PH_GAP;
                end
            end
            PH_GAP: begin
                take_varint(b, done, v);
                if (done) begin
                    t = 34'(y_pos) + 34'(v);
                    y_pos = (t > 34'(Y_LIMIT)) ? Y_LIMIT : t[16:0];
                    dec_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                take_varint(b, done, v);
                if (done) begin
                    t = 34'(v) + 34'd1;
                    run_len = (t > 34'(Y_LIMIT)) ? Y_LIMIT : t[16:0];
                    dec_phase = PH_IDHI;
                end
            end
            PH_IDHI: begin
                if (id_width_r == 2'd2) begin
                    id_hi = b;
                    dec_phase = PH_IDLO;
                end
                else begin
                    emit_segment({8'h00, b});
                end
            end
            PH_IDLO: emit_segment({id_hi, b});
            default: dec_phase = PH_DONE;
        endcase
    endtask

    // one item; push is left high so back-to-back sends need no gap
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            push = 1'b0;
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge clk);
            @(negedge clk);
        end
        push = 1'b1;
        stream_byte = b;
        do
            @(posedge clk);
        while (full);
        decode_byte(b);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        push = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_data = $urandom;
        case (idx)
            REG_DEPTH_Z:      depth_z_r = value[15:0];
            REG_COLUMN_COUNT: col_count_r = value;
            REG_ID_WIDTH:     id_width_r = value[1:0];
            default: ;
        endcase
    endtask

    // pad adds zero groups; junk fills all five groups and trails random bits
    task automatic send_varint(input logic [31:0] v, input int pad, input bit junk);
        logic [7:0] g;
        int         k;
        if (junk) begin
            for (int i = 0; i < 5; i++) begin
                g = 8'(v >> (7 * i)) & DATA_MASK;
                if (i == 4)
                    g = g | (8'($urandom) & 8'h70);
                send_byte(g | CONT_FLAG);
            end
            k = $urandom_range(0, 3);
            repeat (k) send_byte(8'($urandom) | CONT_FLAG);
            send_byte(8'($urandom) & DATA_MASK);
        end
        else begin
            do begin
                g = 8'(v) & DATA_MASK;
                v = v >> 7;
                if (v != 0 || pad > 0)
                    g = g | CONT_FLAG;
                send_byte(g);
            end while (v != 0);
            while (pad > 0) begin
                pad--;
                send_byte(pad > 0 ? CONT_FLAG : 8'h00);
            end
        end
    endtask

    task automatic send_segment(input logic [31:0] gap, input logic [31:0] run_m1,
                                input logic [15:0] id);
        send_varint(gap, 0, 1'b0);
        send_varint(run_m1, 0, 1'b0);
        if (id_width_r == 2'd2)
            send_byte(id[15:8]);
        send_byte(id[7:0]);
    endtask

    function automatic logic [31:0] pick_value(input int small_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, small_max);
        if (r < 90) return $urandom_range(0, 70000);
        return $urandom;
    endfunction

    task automatic send_random_column(input int max_segs);
        int nseg;
        nseg = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, max_segs);
        send_varint(pick_value(4), $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0,
                    $urandom_range(0, 14) == 0);
        send_varint(nseg, $urandom_range(0, 9) == 0 ? 1 : 0, 1'b0);
        repeat (nseg) begin
            send_varint(pick_value(20), $urandom_range(0, 11) == 0 ? 2 : 0,
                        $urandom_range(0, 19) == 0);
            send_varint(pick_value(40), 0, $urandom_range(0, 19) == 0);
            if (id_width_r == 2'd2)
                send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
    endtask

    // raw bytes; segment counts kept tiny so the stream can resync
    task automatic send_noise(input int n);
        repeat (n) begin
            if (dec_phase == PH_COUNT)
                send_byte(8'($urandom_range(0, 3)));
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic resync();
        while (dec_phase != PH_DELTA)
            send_byte(8'h00);
    endtask

    task automatic pick_config();
        int r;
        r = $urandom_range(0, 3);
        write_reg(REG_DEPTH_Z, r == 0 ? 32'd0 : r == 1 ? 32'd1 :
                  r == 2 ? 32'hFFFF : 32'($urandom_range(2, 300)));
        write_reg(REG_ID_WIDTH, $urandom_range(0, 3));
        write_reg(REG_COLUMN_COUNT, $urandom_range(0, 1) ? 32'hFFFF_FFFF
                  : cols_done + 32'd100000);
    endtask

    task automatic test_directed();
        write_reg(REG_COLUMN_COUNT, 32'h0);
        write_reg(REG_COLUMN_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_DEPTH_Z, 32'h0);
        write_reg(REG_ID_WIDTH, 32'd1);
        send_varint(0, 0, 1'b0);
        send_varint(2, 0, 1'b0);
        send_segment(0, 0, 16'h0000);
        send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h00FF);
        send_varint(32'hFFFF_FF00, 0, 1'b1);
        send_varint(0, 2, 1'b0);
        send_varint(5, 0, 1'b0);
        send_varint(1, 0, 1'b0);
        send_segment(65535, 32'hFFFF, 16'h0080);
        wait_drained();
        write_reg(REG_DEPTH_Z, 32'hFFFF);
        write_reg(REG_ID_WIDTH, 32'd2);
        send_varint(32'h0001_2345, 0, 1'b0);
        send_varint(2, 0, 1'b0);
        send_segment(3, 7, 16'hFFFF);
        send_segment(65530, 65535, 16'h0100);
        wait_drained();
        write_reg(REG_DEPTH_Z, 32'd3);
        write_reg(REG_ID_WIDTH, 32'd3);
        send_varint(7, 0, 1'b0);
        send_varint(1, 0, 1'b0);
        send_segment(1, 1, 16'h007F);
        wait_drained();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n);
        int start;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        pick_config();
        start = cycles;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                send_random_column(4);
            end
            else begin
                send_noise($urandom_range(1, 8));
                resync();
            end
        end
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        pop_stall_pct = 30;
        repeat (5) send_random_column(3);
        wait_drained();
        repeat (5) send_random_column(3);
        wait_drained();
    endtask

    task automatic test_end_of_stream();
        int style;
        style = $urandom_range(0, 2);
        send_idle_pct = 6;
        pop_stall_pct = 6;
        if (style == 0) begin
            write_reg(REG_COLUMN_COUNT, 32'h0);
            send_byte(8'($urandom));
        end
        else begin
            write_reg(REG_COLUMN_COUNT, cols_done + 32'd1);
            send_varint(1, 0, 1'b0);
            if (style == 1) begin
                send_varint(2, 0, 1'b0);
                send_segment(2, 3, 16'h0042);
                send_segment(0, 0, 16'h0024);
            end
            else begin
                send_varint(0, 0, 1'b0);
            end
        end
        // after the end marker the decoder swallows everything
        repeat (12) send_byte(8'($urandom));
        wait_drained();
    endtask

    initial begin
        depth_z_r = 16'd1;
        col_count_r = '0;
        id_width_r = 2'd1;
        dec_phase = PH_DELTA;
        acc = '0;
        acc_shift = '0;
        col_idx = '0;
        cols_done = '0;
        segs_left = '0;
        y_pos = '0;
        run_len = '0;
        id_hi = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(posedge clk);
        test_directed();
        test_random(0, 0, 14);
        test_random(61, 0, 14);
        test_pause_until_drained();
        test_random(0, 61, 14);
        test_random(6, 6, 14);
        test_random(0, 0, 10);
        test_end_of_stream();
        if (mismatches == 0 && expected_recs.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
